>>> hw/rtl/hra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hra_pkg
// Shared types and constants for the heart rate averager.
// ----------------------------------------------------------------------------
package hra_pkg;

  localparam int IR_W      = 18;
  localparam int TIME_W    = 32;
  localparam int BPM_W     = 8;
  localparam int AVG_W     = 10;
  localparam int FILT_W    = 12;
  localparam int HIST_W    = 10;
  localparam int WSUM_W    = 14;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 18;
  localparam int FIR_TAPS  = 4;

  localparam int DIVD_W    = 18;
  localparam int DIVS_W    = 16;

  localparam int S_DATA_W  = 56;
  localparam int M_DATA_W  = 32;

  localparam logic [STATUS_W-1:0] ST_NO_FINGER = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_BEAT   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ACCEPTED  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_OUT_BAND  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_FINGER_LEVEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BPM_LOW      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BPM_HIGH     = 2'd2;

  localparam logic [IR_W-1:0]  FINGER_LEVEL_RST = 18'd50000;
  localparam logic [BPM_W-1:0] BPM_LOW_RST      = 8'd40;
  localparam logic [BPM_W-1:0] BPM_HIGH_RST     = 8'd150;

  localparam logic [DIVD_W-1:0] RATE_DIVIDEND = 18'd60000;
  localparam logic [BPM_W-1:0]  BPM_MAX       = 8'd255;
  localparam logic [AVG_W-1:0]  AVG_MAX       = 10'd1023;
  localparam logic [FILT_W-1:0] FILT_MAX      = 12'd4095;

  typedef struct packed {
    logic                load_in;
    logic                beat_take;
    logic                div_go_rate;
    logic                set_rate;
    logic                ring_write;
    logic                fir_shift;
    logic                set_filt;
    logic                out_load;
    logic [STATUS_W-1:0] status;
  } hra_cmd_t;

  typedef struct packed {
    logic finger;
    logic beat;
    logic iv_zero;
    logic iv_big;
    logic in_band;
    logic div_done;
    logic out_full;
  } hra_stat_t;

endpackage

>>> hw/rtl/heart_rate_averager_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heart_rate_averager_unit
// Beat rate from beat intervals, averaging ring and four-tap fir smoother.
// ----------------------------------------------------------------------------
// Input items arrive on s_tvalid/s_tready/s_tdata/s_tuser, one result item per
// input item leaves on m_tvalid/m_tready/m_tdata/m_tuser. Configuration goes
// through cfg_we/cfg_index/cfg_data; the user must write it only while the
// block is idle, which the block itself does not enforce. One item is worked
// on at a time. An item with no finger or no beat goes from the check to the
// output. A beat runs the restoring divider for 60000/interval: start, 18
// quotient steps and done. An in-band beat then goes through the ring update,
// fir shift and fir scaling to the output, an out-of-band beat straight to the
// output. A zero interval or one of 65536 ms or more skips the division.
// The fir scaling by 10*RING_DEPTH is a combinational reciprocal multiply.
// s_tready is high only while the sequencer is idle. A finished result sits
// in the output register; the next item is accepted while it waits, and its
// own result is held back until the receiver has taken the earlier one.
// Reset (rst, synchronous) restores the threshold and band registers, clears
// the beat time, ring, fir history and held values, and drops m_tvalid.
// ----------------------------------------------------------------------------
module heart_rate_averager_unit
  import hra_pkg::*;
#(
  parameter int RING_DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_DATA_W-1:0]  s_tdata,   // ir_sample[17:0], time_ms[49:18], zero fill
  input  logic                 s_tuser,   // beat_flag
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_DATA_W-1:0]  m_tdata,   // instant_bpm[7:0], average_bpm_quarters[17:8],
                                          // filtered_bpm_sixteenths[29:18], zero fill
  output logic [STATUS_W-1:0]  m_tuser,   // status
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  hra_cmd_t  cmd;
  hra_stat_t stat;

  hra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  hra_datapath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

>>> hw/rtl/hra_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hra_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hra_div
  import hra_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [DIVS_W-1:0] divisor,
  output logic              done,
  output logic [DIVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVD_W + 1);

  logic [DIVS_W-1:0] rem;
  logic [DIVS_W-1:0] dvs;
  logic [DIVD_W-1:0] quo;
  logic [CNT_W-1:0]  cnt;
  logic              busy;

  logic [DIVS_W:0]   trial;
  logic              ge;
  logic [DIVS_W:0]   diff;

  assign trial = {rem, quo[DIVD_W-1]};
  assign ge    = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIVD_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
      quo <= {quo[DIVD_W-2:0], ge};
    end
  end

  assign quotient = quo;

endmodule

>>> hw/rtl/hra_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hra_ctrl
// Sequencer for one item: check, rate division, ring update, fir, output.
// ----------------------------------------------------------------------------
module hra_ctrl
  import hra_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  hra_stat_t stat,
  output hra_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CHECK  = 4'd1;
  localparam logic [3:0] S_START  = 4'd2;
  localparam logic [3:0] S_RDIV   = 4'd3;
  localparam logic [3:0] S_RATE   = 4'd4;
  localparam logic [3:0] S_BAND   = 4'd5;
  localparam logic [3:0] S_FIRW   = 4'd6;
  localparam logic [3:0] S_FILT   = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;

  logic [3:0]          state;
  logic [3:0]          state_next;
  logic [STATUS_W-1:0] status;
  logic [STATUS_W-1:0] status_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next  = state;
    status_next = status;
    cmd         = '0;
    cmd.status  = status;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!stat.finger) begin
          status_next = ST_NO_FINGER;
          state_next  = S_OUT;
        end else if (!stat.beat) begin
          status_next = ST_NO_BEAT;
          state_next  = S_OUT;
        end else begin
          cmd.beat_take = 1'b1;
          state_next    = S_START;
        end
      end
      S_START: begin
        // zero or very long intervals need no division
        if (stat.iv_zero || stat.iv_big) begin
          state_next = S_RATE;
        end else begin
          cmd.div_go_rate = 1'b1;
          state_next      = S_RDIV;
        end
      end
      S_RDIV: begin
        if (stat.div_done) begin
          state_next = S_RATE;
        end
      end
      S_RATE: begin
        cmd.set_rate = 1'b1;
        state_next   = S_BAND;
      end
      S_BAND: begin
        if (stat.in_band) begin
          cmd.ring_write = 1'b1;
          status_next    = ST_ACCEPTED;
          state_next     = S_FIRW;
        end else begin
          status_next = ST_OUT_BAND;
          state_next  = S_OUT;
        end
      end
      S_FIRW: begin
        cmd.fir_shift = 1'b1;
        state_next    = S_FILT;
      end
      S_FILT: begin
        cmd.set_filt = 1'b1;
        state_next   = S_OUT;
      end
      S_OUT: begin
        if (!stat.out_full) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      status <= ST_NO_FINGER;
    end else begin
      state  <= state_next;
      status <= status_next;
    end
  end

endmodule

>>> hw/rtl/hra_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hra_datapath
// Config registers, beat timing, rate ring, fir history and output register.
// ----------------------------------------------------------------------------
module hra_datapath
  import hra_pkg::*;
#(
  parameter int RING_DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  hra_cmd_t             cmd,
  output hra_stat_t            stat,
  input  logic [S_DATA_W-1:0]  s_tdata,
  input  logic                 s_tuser,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 m_tready,
  output logic                 m_tvalid,
  output logic [M_DATA_W-1:0]  m_tdata,
  output logic [STATUS_W-1:0]  m_tuser
);

  localparam int SLOT_W   = $clog2(RING_DEPTH);
  localparam int SUM_W    = BPM_W + $clog2(RING_DEPTH);
  localparam int FIR_DIV  = 10 * RING_DEPTH;
  localparam int RECIP_W  = 20;
  localparam int RECIP_SH = DIVD_W + $clog2(FIR_DIV);
  localparam int PROD_W   = DIVD_W + RECIP_W;
  // rounded-up reciprocal, exact for any 18-bit dividend
  localparam logic [RECIP_W-1:0] FIR_RECIP =
    RECIP_W'(((64'd1 << RECIP_SH) + 64'(FIR_DIV) - 64'd1) / 64'(FIR_DIV));

  // config
  logic [IR_W-1:0]  finger_level;
  logic [BPM_W-1:0] bpm_low;
  logic [BPM_W-1:0] bpm_high;

  // item
  logic [IR_W-1:0]   ir_sample;
  logic              beat_flag;
  logic [TIME_W-1:0] time_ms;

  // state
  logic [TIME_W-1:0] last_beat_time;
  logic [TIME_W-1:0] interval;
  logic [BPM_W-1:0]  held_instant_bpm;
  logic [FILT_W-1:0] held_filtered;
  logic [BPM_W-1:0]  rate_ring [RING_DEPTH];
  logic [SLOT_W-1:0] ring_slot;
  logic [SUM_W-1:0]  ring_sum;
  logic [HIST_W-1:0] fir_history [FIR_TAPS];
  logic [WSUM_W-1:0] fir_wsum;

  logic [11:0]       sum_ext;
  logic [AVG_W-1:0]  avg;
  logic [WSUM_W-1:0] wsum_next;
  logic [BPM_W-1:0]  rate_calc;
  logic [FILT_W-1:0] filt_calc;
  logic [PROD_W-1:0] filt_prod;
  logic [PROD_W-1:0] filt_quo;

  logic              div_start;
  logic [DIVD_W-1:0] div_dividend;
  logic [DIVS_W-1:0] div_divisor;
  logic              div_done;
  logic [DIVD_W-1:0] div_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      finger_level <= FINGER_LEVEL_RST;
      bpm_low      <= BPM_LOW_RST;
      bpm_high     <= BPM_HIGH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FINGER_LEVEL: finger_level <= cfg_data[IR_W-1:0];
        REG_BPM_LOW:      bpm_low      <= cfg_data[BPM_W-1:0];
        REG_BPM_HIGH:     bpm_high     <= cfg_data[BPM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      ir_sample <= s_tdata[IR_W-1:0];
      time_ms   <= s_tdata[IR_W +: TIME_W];
      beat_flag <= s_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.beat_take) begin
      interval <= time_ms - last_beat_time;
    end
  end

  // capped ring sum
  assign sum_ext = 12'(ring_sum);
  assign avg     = (sum_ext > 12'(AVG_MAX)) ? AVG_MAX : sum_ext[AVG_W-1:0];

  // weights 1,2,3,4 with the newest sample entering at weight 1
  assign wsum_next = WSUM_W'(avg)
                   + WSUM_W'({fir_history[0], 1'b0})
                   + WSUM_W'({fir_history[1], 1'b0}) + WSUM_W'(fir_history[1])
                   + WSUM_W'({fir_history[2], 2'b00});

  always_comb begin
    if (interval == '0) begin
      rate_calc = BPM_MAX;
    end else if (interval[TIME_W-1:DIVS_W] != '0) begin
      rate_calc = '0;
    end else if (div_q[DIVD_W-1:BPM_W] != '0) begin
      rate_calc = BPM_MAX;
    end else begin
      rate_calc = div_q[BPM_W-1:0];
    end
  end

  // 16*w / (10*RING_DEPTH) by reciprocal multiply
  assign filt_prod = PROD_W'({fir_wsum, 4'b0000}) * PROD_W'(FIR_RECIP);
  assign filt_quo  = filt_prod >> RECIP_SH;
  assign filt_calc = (filt_quo[PROD_W-1:FILT_W] != '0) ? FILT_MAX : filt_quo[FILT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      last_beat_time   <= '0;
      held_instant_bpm <= '0;
      held_filtered    <= '0;
      ring_slot        <= '0;
      ring_sum         <= '0;
      for (int k = 0; k < RING_DEPTH; k++) begin
        rate_ring[k] <= '0;
      end
      for (int k = 0; k < FIR_TAPS; k++) begin
        fir_history[k] <= '0;
      end
    end else begin
      if (cmd.beat_take) begin
        last_beat_time <= time_ms;
      end
      if (cmd.set_rate) begin
        held_instant_bpm <= rate_calc;
      end
      if (cmd.ring_write) begin
        rate_ring[ring_slot] <= held_instant_bpm;
        ring_sum  <= ring_sum - SUM_W'(rate_ring[ring_slot]) + SUM_W'(held_instant_bpm);
        ring_slot <= (ring_slot == SLOT_W'(RING_DEPTH - 1)) ? '0 : ring_slot + SLOT_W'(1);
      end
      if (cmd.fir_shift) begin
        fir_history[0] <= avg;
        for (int k = 1; k < FIR_TAPS; k++) begin
          fir_history[k] <= fir_history[k-1];
        end
      end
      if (cmd.set_filt) begin
        held_filtered <= filt_calc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fir_shift) begin
      fir_wsum <= wsum_next;
    end
  end

  assign div_start    = cmd.div_go_rate;
  assign div_dividend = RATE_DIVIDEND;
  assign div_divisor  = interval[DIVS_W-1:0];

  hra_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // output register, freed by the downstream handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {2'b00, held_filtered, avg, held_instant_bpm};
      m_tuser <= cmd.status;
    end
  end

  assign stat.finger   = ir_sample >= finger_level;
  assign stat.beat     = beat_flag;
  assign stat.iv_zero  = interval == '0;
  assign stat.iv_big   = interval[TIME_W-1:DIVS_W] != '0;
  assign stat.in_band  = (held_instant_bpm >= bpm_low) && (held_instant_bpm <= bpm_high);
  assign stat.div_done = div_done;
  assign stat.out_full = m_tvalid && !m_tready;

endmodule
